[hdl/poc_pkg.sv]
// picture order count package: payload structs, register indexes, opcodes, log2 clamp
// no dependencies
package poc_pkg;

   localparam int TableDepth = 256;
   localparam int TableAw    = 8;

   typedef enum logic [2:0] {
      CSR_ORDER_MODE    = 3'd0,
      CSR_LOG2_MAX_LSB  = 3'd1,
      CSR_LOG2_MAX_FNUM = 3'd2,
      CSR_CYCLE_LENGTH  = 3'd3,
      CSR_NON_REF_OFS   = 3'd4,
      CSR_TOP_BOT_OFS   = 3'd5
   } csr_index_type;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [7:0]         table_index;
      logic signed [31:0] table_value;
      logic               is_idr;
      logic               is_reference;
      logic               field_picture;
      logic [15:0]        frame_number;
      logic [15:0]        order_lsb;
      logic signed [31:0] delta_bottom;
      logic signed [31:0] delta_first;
      logic signed [31:0] delta_second;
   } req_type;

   typedef struct packed {
      logic signed [31:0] order_count;
      logic signed [31:0] top_count;
      logic signed [31:0] bottom_count;
      logic [30:0]        frame_offset;
   } rsp_type;

   function automatic logic [4:0] clamp_log2(input logic [4:0] v);
      logic [4:0] r;
      if (v < 5'd4) r = 5'd4;
      else if (v > 5'd16) r = 5'd16;
      else r = v;
      return r;
   endfunction

endpackage

[hdl/poc_div.sv]
// serial restoring divider: 33-bit dividend by 8-bit divisor, one bit a cycle
// depends on poc_pkg
module poc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [7:0]  divisor,
   output logic        done,
   output logic [32:0] quotient,
   output logic [7:0]  remainder
);
   import poc_pkg::*;

   logic [32:0] q_ff, q_in;
   logic [8:0]  r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [8:0]  trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[7:0], q_ff[32]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[31:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[7:0];
endmodule

[hdl/picture_order_count_calc_top.sv]
// picture order count top: registers, offset table, sequencer, shared adder
// depends on poc_pkg and poc_div
// A load beat writes the table in ST_LOAD. A compute beat in modes 0, 2 and 3 goes
// from ST_FOFF to ST_OUT. In mode 1 it sums the table in ST_SUM, starts and runs
// the serial divider in ST_DIVGO and ST_DIV, takes a 32x32 multiply in ST_MUL and
// sums the partial cycle in ST_PART (these three skipped when absn is zero), then
// does two add steps in ST_FIN1 and ST_FIN2 and waits in ST_OUT for any stall.
// The offset table has a write and a read port, one word read per cycle, and its
// words read as garbage until loaded. No new beat is taken until the result is out.
module picture_order_count_calc_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  poc_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output poc_pkg::rsp_type     rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import poc_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_FOFF  = 11'b00000000010,
      ST_SUM   = 11'b00000000100,
      ST_DIVGO = 11'b00000001000,
      ST_DIV   = 11'b00000010000,
      ST_MUL   = 11'b00000100000,
      ST_PART  = 11'b00001000000,
      ST_FIN1  = 11'b00010000000,
      ST_FIN2  = 11'b00100000000,
      ST_OUT   = 11'b01000000000,
      ST_LOAD  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic [4:0]  llsb_ff, lfrm_ff;
   logic [7:0]  clen_ff;
   logic [31:0] nro_ff, tbo_ff;
   logic [31:0] prev_msb_ff;
   logic [15:0] prev_lsb_ff, prev_frame_ff;
   logic [30:0] prev_offset_ff;

   req_type     req_ff;
   logic [30:0] foff_ff;
   logic [15:0] fnum_ff;
   logic [31:0] acc_ff, sum_ff, top_ff, bot_ff;
   logic [32:0] absn_ff;
   logic [8:0]  idx_ff;
   logic [7:0]  pos_ff;
   logic        rd_pend_ff;

   logic [31:0] table_mem [TableDepth];
   logic [31:0] rd_data_ff;

   // adder shared by the sum, partial and final add states
   logic [31:0] add_a, add_b, add_y;
   assign add_y = add_a + add_b;

   logic        div_start, div_done;
   logic [32:0] div_q;
   logic [7:0]  div_r;

   poc_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(absn_ff - 33'd1), .divisor(clen_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   logic        accept;
   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign div_start = state_ff == ST_DIVGO;

   // combinational pieces: mode 0 msb and lsb, and the wrapped frame number
   logic [4:0]  ll, lf;
   logic [16:0] max_lsb, max_frame;
   logic [15:0] lsb, pl, fnum_m;
   logic [31:0] pm, msb;
   always_comb begin
      ll        = clamp_log2(llsb_ff);
      lf        = clamp_log2(lfrm_ff);
      max_lsb   = 17'd1 << ll;
      max_frame = 17'd1 << lf;
      lsb       = req_ff.order_lsb & 16'(max_lsb - 17'd1);
      pl        = req_ff.is_idr ? 16'd0 : (prev_lsb_ff & 16'(max_lsb - 17'd1));
      pm        = req_ff.is_idr ? 32'd0 : prev_msb_ff;
      if (lsb < pl && {1'b0, pl - lsb} >= (max_lsb >> 1))
         msb = pm + 32'(max_lsb);
      else if (lsb > pl && {1'b0, lsb - pl} > (max_lsb >> 1))
         msb = pm - 32'(max_lsb);
      else
         msb = pm;
      fnum_m = req_ff.frame_number & 16'(max_frame - 17'd1);
   end

   // 32x32 low product, registered
   logic [31:0] prod_ff;
   always_ff @(posedge clock) prod_ff <= div_q[31:0] * sum_ff;

   // adder operand select
   always_comb begin
      add_a = acc_ff;
      add_b = '0;
      case (state_ff)
         ST_SUM, ST_PART: begin
            add_a = acc_ff;
            add_b = (rd_pend_ff && idx_ff != 9'd0) ? rd_data_ff : 32'd0;
         end
         ST_FIN1: begin
            add_a = acc_ff;
            add_b = req_ff.delta_first;
         end
         ST_FIN2: begin
            add_a = top_ff;
            add_b = acc_ff;
         end
         default: begin
            add_a = acc_ff;
            add_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = (req_data.opcode == OP_LOAD) ? ST_LOAD : ST_FOFF;
         ST_LOAD:  state_in = ST_IDLE;
         ST_FOFF:  state_in = (mode_ff == 2'd1) ? ST_SUM : ST_OUT;
         ST_SUM:   if (idx_ff == {1'b0, clen_ff}) state_in = ST_DIVGO;
         ST_DIVGO: state_in = (absn_ff == 33'd0) ? ST_FIN1 : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_PART;
         ST_PART:  if (idx_ff == {1'b0, pos_ff} + 9'd1) state_in = ST_FIN1;
         ST_FIN1:  state_in = ST_FIN2;
         ST_FIN2:  state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // table memory, one write port and one read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD)
         table_mem[req_ff.table_index] <= req_ff.table_value;
      rd_data_ff <= table_mem[idx_ff[TableAw-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= '0;
         llsb_ff        <= 5'd4;
         lfrm_ff        <= 5'd4;
         clen_ff        <= '0;
         nro_ff         <= '0;
         tbo_ff         <= '0;
         prev_msb_ff    <= '0;
         prev_lsb_ff    <= '0;
         prev_frame_ff  <= '0;
         prev_offset_ff <= '0;
         rd_pend_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_ORDER_MODE:    mode_ff <= csr_data[1:0];
               CSR_LOG2_MAX_LSB:  llsb_ff <= csr_data[4:0];
               CSR_LOG2_MAX_FNUM: lfrm_ff <= csr_data[4:0];
               CSR_CYCLE_LENGTH:  clen_ff <= csr_data[7:0];
               CSR_NON_REF_OFS:   nro_ff  <= csr_data;
               CSR_TOP_BOT_OFS:   tbo_ff  <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_FOFF) begin
            prev_frame_ff  <= fnum_m;
            prev_offset_ff <= req_ff.is_idr ? 31'd0 :
               (fnum_m < prev_frame_ff) ? prev_offset_ff + 31'(max_frame) : prev_offset_ff;
            if (mode_ff == 2'd0) begin
               if (req_ff.is_reference) begin
                  prev_msb_ff <= msb;
                  prev_lsb_ff <= lsb;
               end else if (req_ff.is_idr) begin
                  prev_msb_ff <= '0;
                  prev_lsb_ff <= '0;
               end
            end
         end
         rd_pend_ff <= state_in == ST_SUM || state_in == ST_PART;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      case (state_ff)
         ST_FOFF: begin
            logic [30:0] fo;
            logic [32:0] an;
            fo = req_ff.is_idr ? 31'd0 :
               (fnum_m < prev_frame_ff) ? prev_offset_ff + 31'(max_frame) : prev_offset_ff;
            foff_ff <= fo;
            fnum_ff <= fnum_m;
            an = (clen_ff != 8'd0) ? {2'b0, fo} + {17'd0, fnum_m} : 33'd0;
            if (!req_ff.is_reference && an != 33'd0) an = an - 33'd1;
            absn_ff <= an;
            idx_ff  <= '0;
            acc_ff  <= '0;
            if (mode_ff == 2'd0) begin
               top_ff <= msb + {16'd0, lsb};
               bot_ff <= req_ff.field_picture ? msb + {16'd0, lsb}
                                              : msb + {16'd0, lsb} + req_ff.delta_bottom;
            end else begin
               logic [31:0] t;
               t = req_ff.is_idr ? 32'd0 :
                  ((({1'b0, fo} + {16'd0, fnum_m}) << 1) - (req_ff.is_reference ? 32'd0 : 32'd1));
               top_ff <= t;
               bot_ff <= t;
            end
         end
         ST_SUM: begin
            // the read data is registered, so the read address leads it
            acc_ff <= add_y;
            if (idx_ff != {1'b0, clen_ff}) idx_ff <= idx_ff + 9'd1;
            else begin
               sum_ff <= add_y;
            end
         end
         ST_DIVGO: begin
            acc_ff <= '0;
            idx_ff <= '0;
         end
         ST_DIV: if (div_done) pos_ff <= div_r;
         ST_MUL: acc_ff <= prod_ff;
         ST_PART: begin
            acc_ff <= add_y;
            idx_ff <= idx_ff + 9'd1;
         end
         ST_FIN1: begin
            top_ff <= add_y + (req_ff.is_reference ? 32'd0 : nro_ff);
            acc_ff <= tbo_ff + req_ff.delta_second;
         end
         ST_FIN2: bot_ff <= add_y;
         default: ;
      endcase
   end

   // result comes straight from the count registers, which hold still in ST_OUT
   assign rsp_valid = state_ff == ST_OUT;
   always_comb begin
      rsp_data.top_count    = top_ff;
      rsp_data.bottom_count = bot_ff;
      rsp_data.order_count  = ($signed(top_ff) < $signed(bot_ff)) ? top_ff : bot_ff;
      rsp_data.frame_offset = foff_ff;
   end

   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_div_in_mode1: assert property (@(posedge clock) disable iff (reset)
      div_start |-> mode_ff == 2'd1) else $error("divider started outside mode 1");
endmodule
